### sv/smt_pkg.sv
// shared constants and types for the subscription match table
package smt_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 16;

    localparam int OP_W      = 2;
    localparam int ID_W      = 32;
    localparam int MASK_W    = 32;
    localparam int USED_W    = 5;
    localparam int S_DATA_W  = 2 * ID_W + MASK_W;
    localparam int M_DATA_W  = 8;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_MATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [MASK_W-1:0] t_mask;

endpackage

### sv/subscription_match_table_core.sv
// subscription match table: identifier / stream-mask store with add, match and clear
// an accepted word is held in the input register, then moves into the result register
// throughput: one word per cycle while the result side keeps taking words
// the table is flip-flops compared in parallel in the single stage between
// the input register and the result register
// reset clears the entry count and both valid flags; entry contents are not cleared
// and are only ever read below the count, so no clearing pass is needed
module subscription_match_table_core
    import smt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // process_id, other_process_id, stream_mask
    input  logic [OP_W-1:0]     i_s_tuser,  // operation
    // result channel
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata   // accepted, entries_used, zero pad
);

    // count must be able to hold the table depth itself
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // input register
    logic            r_in_valid;
    logic [OP_W-1:0] r_op;
    t_id             r_pid;
    t_id             r_other;
    t_mask           r_mask;

    // table storage and count
    t_id             r_ids   [TABLE_ENTRIES];
    t_mask           r_masks [TABLE_ENTRIES];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic              r_out_valid;
    logic              r_accepted;
    logic [USED_W-1:0] r_used;
    logic              n_accepted;

    // stage moves forward when the result slot is free or being emptied
    logic advance;
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // per-entry compare results
    logic [TABLE_ENTRIES-1:0] entry_valid;
    logic [TABLE_ENTRIES-1:0] add_hit;
    logic [TABLE_ENTRIES-1:0] match_hit;
    logic [TABLE_ENTRIES-1:0] append_sel;
    logic                     add_ok;
    logic                     table_full;
    logic                     do_merge;
    logic                     do_append;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_valid[i] = CNT_W'(i) < r_count;
            add_hit[i]     = entry_valid[i] && (r_ids[i] == r_pid);
            // overlap on the query mask and either identifier, secondary only if nonzero
            match_hit[i]   = entry_valid[i] && ((r_masks[i] & r_mask) != '0) &&
                             ((r_ids[i] == r_pid) ||
                              ((r_other != '0) && (r_ids[i] == r_other)));
            append_sel[i]  = CNT_W'(i) == r_count;
        end
    end

    assign table_full = r_count >= CNT_W'(TABLE_ENTRIES);
    assign add_ok     = (r_pid != '0) && (r_mask != '0);
    // identifiers are unique in the table, so merging into every hit is the lowest hit
    assign do_merge   = add_ok && (add_hit != '0);
    assign do_append  = add_ok && (add_hit == '0) && !table_full;

    always_comb begin
        n_count    = r_count;
        n_accepted = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                n_accepted = do_merge || do_append;
                if (do_append) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_MATCH: begin
                n_accepted = match_hit != '0;
            end
            OP_CLEAR: begin
                n_count    = '0;
                n_accepted = 1'b1;
            end
            default: begin
                // unused code leaves everything as it is
                n_accepted = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op    <= i_s_tuser;
            r_pid   <= i_s_tdata[ID_W-1:0];
            r_other <= i_s_tdata[2*ID_W-1:ID_W];
            r_mask  <= i_s_tdata[S_DATA_W-1:2*ID_W];
        end
    end

    // result payload, count wraps into the five-bit field
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_accepted <= n_accepted;
            r_used     <= USED_W'(n_count);
        end
    end

    // table writes: merge into a hit, or append at the count
    always_ff @(posedge i_clk) begin
        if (advance && (r_op == OP_ADD)) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (do_merge && add_hit[i]) begin
                    r_masks[i] <= r_masks[i] | r_mask;
                end else if (do_append && append_sel[i]) begin
                    r_ids[i]   <= r_pid;
                    r_masks[i] <= r_mask;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W - USED_W - 1){1'b0}}, r_used, r_accepted};

    // the count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table depth");

    // the count only moves when a word advances into the result slot
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_count))
        else $error("entry count changed without an item");

    // a clear leaves the table empty
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_op == OP_CLEAR)) |=> (r_count == '0) && r_accepted)
        else $error("clear did not empty the table");

    // an add never grows the count by more than one entry
    a_add_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_op == OP_ADD)) |=>
            ((r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1))))
        else $error("add changed the count by more than one");

    // an add with a zero operand is rejected and leaves the count alone
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_op == OP_ADD) && !add_ok) |=> (r_count == $past(r_count)) && !r_accepted)
        else $error("zero operand add was not rejected");

endmodule

### test/subscription_match_table_core_tb.sv
// testbench for subscription_match_table_core: directed and random add, match and clear words
`timescale 1ns / 1ps

module subscription_match_table_core_tb;
    import smt_pkg::*;

    localparam int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_SIZE = 24;
    localparam int RANDOM_WORDS = 200;

    typedef struct packed {
        logic              accepted;
        logic [USED_W-1:0] entries_used;
    } t_result_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;  // process_id, other_process_id, stream_mask
    logic [OP_W-1:0]     i_s_tuser = '0;  // operation
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;       // accepted, entries_used, zero pad

    // predicted table contents
    t_id   table_ids [TABLE_ENTRIES];
    t_mask table_masks [TABLE_ENTRIES];
    int    table_count = 0;

    t_result_word pending_results[$];
    int           mismatch_count = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    t_id          id_pool [POOL_SIZE];

    subscription_match_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // table behavior for one accepted word
    function automatic t_result_word table_apply(logic [OP_W-1:0] op, t_id pid, t_id other,
                                                 t_mask mask);
        t_result_word res;
        int           hit;
        res.accepted = 1'b0;
        hit = -1;
        case (op)
            OP_ADD: begin
                if (pid != '0 && mask != '0) begin
                    for (int i = 0; i < table_count; i++) begin
                        if (hit < 0 && table_ids[i] == pid) hit = i;
                    end
                    if (hit >= 0) begin
                        table_masks[hit] |= mask;
                        res.accepted = 1'b1;
                    end else if (table_count < TABLE_ENTRIES) begin
                        table_ids[table_count] = pid;
                        table_masks[table_count] = mask;
                        table_count++;
                        res.accepted = 1'b1;
                    end
                end
            end
            OP_MATCH: begin
                for (int i = 0; i < table_count; i++) begin
                    if ((table_masks[i] & mask) != '0 &&
                        (table_ids[i] == pid || (other != '0 && table_ids[i] == other)))
                        res.accepted = 1'b1;
                end
            end
            OP_CLEAR: begin
                table_count = 0;
                res.accepted = 1'b1;
            end
            default: ;
        endcase
        res.entries_used = table_count[USED_W-1:0];
        return res;
    endfunction

    // offer one word, with random sender gaps ahead of it; returns at the accepting edge
    task automatic send_word(logic [OP_W-1:0] op, t_id pid, t_id other, t_mask mask);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {mask, other, pid};
        i_s_tuser <= op;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(table_apply(op, pid, other, mask));
    endtask

    // sender stays quiet until every predicted result has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls and comparison against the oldest prediction
    always @(posedge i_clk) begin
        t_result_word exp_word;
        if (o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: tdata %h", o_m_tdata);
                mismatch_count++;
            end else begin
                exp_word = pending_results.pop_front();
                if (o_m_tdata[0] !== exp_word.accepted) begin
                    $error("accepted: expected %0d, got %0d", exp_word.accepted, o_m_tdata[0]);
                    mismatch_count++;
                end
                if (o_m_tdata[USED_W:1] !== exp_word.entries_used) begin
                    $error("entries_used: expected %0d, got %0d", exp_word.entries_used,
                           o_m_tdata[USED_W:1]);
                    mismatch_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic test_empty_table();
        send_word(OP_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_operands();
        send_word(OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i == 0) send_word(OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
            else send_word(OP_ADD, t_id'(i), 32'h0, t_mask'(1) << i);
        end
        // new id refused, known id still merges
        send_word(OP_ADD, 32'h0001_0000, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_ADD, 32'h0000_0003, 32'h0, 32'h0000_0001);
    endtask

    task automatic test_match_query();
        // primary hit with overlap, primary hit without overlap, secondary only
        send_word(OP_MATCH, 32'h0000_0003, 32'h0, 32'h0000_0001);
        send_word(OP_MATCH, 32'h0000_0005, 32'h0, 32'h0000_0001);
        send_word(OP_MATCH, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_clear();
        send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_MATCH, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    endtask

    function automatic t_mask sparse_mask();
        t_mask m;
        if ($urandom_range(3) == 0) return $urandom;
        m = '0;
        repeat ($urandom_range(1, 3)) m |= t_mask'(1) << $urandom_range(MASK_W - 1);
        return m;
    endfunction

    // mostly adds and matches over a small id pool so the table fills and hits often
    task automatic test_random_traffic(int idle_pct, int stall_pct);
        int              sel;
        logic [OP_W-1:0] op;
        t_id             pid;
        t_id             other;
        t_mask           mask;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            sel = $urandom_range(199);
            pid = id_pool[$urandom_range(POOL_SIZE - 1)];
            other = $urandom;
            mask = sparse_mask();
            if (sel < 10) begin
                op = OP_W'($urandom_range(3));
                pid = $urandom;
                mask = $urandom;
            end else if (sel < 16) begin
                op = OP_UNUSED;
            end else if (sel < 19) begin
                op = OP_CLEAR;
            end else if (sel < 110) begin
                op = OP_ADD;
                if ($urandom_range(19) == 0) pid = '0;
                if ($urandom_range(19) == 0) mask = '0;
            end else begin
                op = OP_MATCH;
                case ($urandom_range(3))
                    0: other = '0;
                    1: other = id_pool[$urandom_range(POOL_SIZE - 1)];
                    2: pid = $urandom;
                    default: ;
                endcase
            end
            send_word(op, pid, other, mask);
        end
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = (i == 0) ? 32'hFFFF_FFFF : ((i == 1) ? 32'h1 : $urandom | 32'h1);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_zero_operands();
        test_full_table();
        test_match_query();
        test_clear();
        drain_results();
        test_random_traffic(0, 0);
        test_random_traffic(80, 0);
        test_random_traffic(0, 80);
        test_random_traffic(6, 6);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
